FILE: hdl/hsm_pkg.sv
package hsm_pkg;

	localparam int unsigned RESET_PULSES = 9;

	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_MEASURE = 2'd1;
	localparam logic [1:0] MODE_INIT    = 2'd2;

	localparam logic [0:0] REG_STATUS = 1'd0;
	localparam logic [0:0] REG_PHASE  = 1'd1;

	localparam logic [7:0] CMD_WRITE_STATUS = 8'h06;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b0_0000_0001,
		ST_RSTLO = 9'b0_0000_0010,
		ST_RSTHI = 9'b0_0000_0100,
		ST_START = 9'b0_0000_1000,
		ST_WRLO  = 9'b0_0001_0000,
		ST_WRHI  = 9'b0_0010_0000,
		ST_WAIT  = 9'b0_0100_0000,
		ST_RDLO  = 9'b0_1000_0000,
		ST_RDHI  = 9'b1_0000_0000
	} state_t;

	typedef struct packed {
		logic       sck;
		logic       data_low;
		logic       busy;
		logic       done;
		logic [7:0] raw;
		logic [7:0] humidity;
		logic       ack_error;
	} result_t;

	// clock and data pull-down levels through the five steps of a start condition
	function automatic logic [1:0] start_levels(input logic [3:0] step);
		logic [1:0] lv;
		case (step)
			4'd0: lv = 2'b10;
			4'd1: lv = 2'b11;
			4'd2: lv = 2'b01;
			4'd3: lv = 2'b11;
			4'd4: lv = 2'b10;
			default: lv = 2'b00;
		endcase
		return lv;
	endfunction

	// piecewise linear humidity, numerator clamped at zero, then divided by 256
	function automatic logic [7:0] humidity_of(input logic [7:0] so);
		logic [15:0] p;
		logic [15:0] num;
		p = 16'(so) * 16'd138;
		if (so < 8'd107) begin
			num = (p < 16'd230) ? 16'd0 : p - 16'd230;
		end else begin
			num = 16'd1306 + 16'(so) * 16'd122;
		end
		return num[15:8];
	endfunction

endpackage

FILE: hdl/hsm_seq.sv
module hsm_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           mode,
	input  logic [7:0]           command,
	input  logic                 data_in,
	input  logic [7:0]           status_value,
	input  logic [7:0]           phase_ticks,
	output hsm_pkg::result_t     res
);

	hsm_pkg::state_t st_q, n_st;
	logic [7:0] pc_q, n_pc;
	logic [3:0] bc_q, n_bc;
	logic [1:0] byc_q, n_byc;
	logic [7:0] sh_q, n_sh;
	logic [7:0] cmd_q, n_cmd;
	logic [7:0] raw_q, n_raw;
	logic       ack_q, n_ack;
	logic       init_q, n_init;
	logic       done;
	logic [7:0] half;
	logic [3:0] bc_inc;
	logic [1:0] lv;

	assign half   = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
	assign bc_inc = bc_q + 4'd1;

	always_comb begin
		n_st   = st_q;
		n_pc   = pc_q;
		n_bc   = bc_q;
		n_byc  = byc_q;
		n_sh   = sh_q;
		n_cmd  = cmd_q;
		n_raw  = raw_q;
		n_ack  = ack_q;
		n_init = init_q;
		done   = 1'b0;
		case (st_q)
			hsm_pkg::ST_WAIT: begin
				if (!data_in) begin
					n_st  = hsm_pkg::ST_RDLO;
					n_pc  = '0;
					n_bc  = '0;
					n_byc = '0;
					n_sh  = '0;
				end
			end
			hsm_pkg::ST_RSTLO, hsm_pkg::ST_RSTHI, hsm_pkg::ST_START, hsm_pkg::ST_WRLO,
			hsm_pkg::ST_WRHI, hsm_pkg::ST_RDLO, hsm_pkg::ST_RDHI: begin
				if ({1'b0, pc_q} + 9'd1 < {1'b0, half}) begin
					n_pc = pc_q + 8'd1;
				end else begin
					n_pc = '0;
					// end of a half phase
					case (st_q)
						hsm_pkg::ST_RSTLO: n_st = hsm_pkg::ST_RSTHI;
						hsm_pkg::ST_RSTHI: begin
							if (32'(bc_inc) >= hsm_pkg::RESET_PULSES) begin
								n_bc = '0;
								n_st = hsm_pkg::ST_START;
							end else begin
								n_bc = bc_inc;
								n_st = hsm_pkg::ST_RSTLO;
							end
						end
						hsm_pkg::ST_START: begin
							if (bc_q < 4'd4) begin
								n_bc = bc_inc;
							end else begin
								n_bc = '0;
								if (byc_q == 2'd3) begin
									// reset start done, issue the real one
									n_byc = '0;
								end else begin
									n_sh = init_q ? hsm_pkg::CMD_WRITE_STATUS : cmd_q;
									n_st = hsm_pkg::ST_WRLO;
								end
							end
						end
						hsm_pkg::ST_WRLO: n_st = hsm_pkg::ST_WRHI;
						hsm_pkg::ST_WRHI: begin
							if (bc_q < 4'd8) begin
								n_sh = {sh_q[6:0], 1'b0};
								n_bc = bc_inc;
								n_st = hsm_pkg::ST_WRLO;
							end else begin
								if (data_in) n_ack = 1'b1;
								n_bc = '0;
								if (init_q && byc_q == 2'd0) begin
									n_sh  = status_value;
									n_byc = 2'd1;
									n_st  = hsm_pkg::ST_WRLO;
								end else if (init_q) begin
									n_st  = hsm_pkg::ST_IDLE;
									n_byc = '0;
									done  = 1'b1;
								end else begin
									n_st = hsm_pkg::ST_WAIT;
								end
							end
						end
						hsm_pkg::ST_RDLO: n_st = hsm_pkg::ST_RDHI;
						hsm_pkg::ST_RDHI: begin
							if (bc_q < 4'd8) begin
								n_sh = {sh_q[6:0], data_in};
								n_bc = bc_inc;
								n_st = hsm_pkg::ST_RDLO;
							end else begin
								if (byc_q == 2'd1) n_raw = sh_q;
								n_bc = '0;
								if (byc_q >= 2'd2) begin
									n_st  = hsm_pkg::ST_IDLE;
									n_byc = '0;
									done  = 1'b1;
								end else begin
									n_byc = byc_q + 2'd1;
									n_sh  = '0;
									n_st  = hsm_pkg::ST_RDLO;
								end
							end
						end
						default: begin
							n_st  = hsm_pkg::ST_IDLE;
							n_bc  = '0;
							n_byc = '0;
							done  = 1'b1;
						end
					endcase
				end
			end
			default: begin
				n_st = hsm_pkg::ST_IDLE;
				if (mode == hsm_pkg::MODE_MEASURE || mode == hsm_pkg::MODE_INIT) begin
					n_ack = 1'b0;
					n_pc  = '0;
					n_bc  = '0;
					n_sh  = '0;
					if (mode == hsm_pkg::MODE_MEASURE) begin
						n_init = 1'b0;
						n_cmd  = command;
						n_byc  = '0;
						n_st   = hsm_pkg::ST_START;
					end else begin
						n_init = 1'b1;
						n_byc  = 2'd3;
						n_st   = hsm_pkg::ST_RSTLO;
					end
				end
			end
		endcase
	end

	assign lv = hsm_pkg::start_levels(n_bc);

	// pin levels follow the state reached after this tick
	always_comb begin
		res           = '0;
		res.busy      = (n_st != hsm_pkg::ST_IDLE);
		res.done      = done;
		res.raw       = n_raw;
		res.humidity  = hsm_pkg::humidity_of(n_raw);
		res.ack_error = n_ack;
		case (n_st)
			hsm_pkg::ST_RSTHI: res.sck = 1'b1;
			hsm_pkg::ST_START: begin
				res.sck      = lv[1];
				res.data_low = lv[0];
			end
			hsm_pkg::ST_WRLO, hsm_pkg::ST_WRHI: begin
				res.sck      = (n_st == hsm_pkg::ST_WRHI);
				res.data_low = (n_bc < 4'd8) ? ~n_sh[7] : 1'b0;
			end
			hsm_pkg::ST_RDLO, hsm_pkg::ST_RDHI: begin
				res.sck      = (n_st == hsm_pkg::ST_RDHI);
				res.data_low = (n_bc >= 4'd8) && (n_byc < 2'd2);
			end
			default: res.sck = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= hsm_pkg::ST_IDLE;
			pc_q   <= '0;
			bc_q   <= '0;
			byc_q  <= '0;
			sh_q   <= '0;
			cmd_q  <= '0;
			raw_q  <= '0;
			ack_q  <= 1'b0;
			init_q <= 1'b0;
		end else if (step) begin
			st_q   <= n_st;
			pc_q   <= n_pc;
			bc_q   <= n_bc;
			byc_q  <= n_byc;
			sh_q   <= n_sh;
			cmd_q  <= n_cmd;
			raw_q  <= n_raw;
			ack_q  <= n_ack;
			init_q <= n_init;
		end
	end

endmodule

FILE: hdl/humidity_sensor_serial_master.sv
// channel | direction | handshake          | payload
// in      | to block  | in_valid/in_ready   | mode, command, data_in
// out     | from block| out_valid/out_ready | sck, data_low, busy_res, done_res,
//         |           |                     | raw_value, humidity, ack_error
// cfg     | to block  | cfg_we              | cfg_index, cfg_data
//
// One tick per transfer; a tick enters every cycle unless the output stalls.
// The input register feeds the sequencer next-state logic and the humidity
// multiply, which land in the output register.
// Reset clears the sequencer to idle and both config registers to 1.
// A stalled output holds the input register; the sequencer advances only
// when a tick moves into the output register.
module humidity_sensor_serial_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] command,
	input  logic       data_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       sck,
	output logic       data_low,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] raw_value,
	output logic [7:0] humidity,
	output logic       ack_error,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] status_q;
	logic [7:0] phase_q;
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] command_s1;
	logic       data_in_s1;
	logic       out_valid_q;
	logic       advance;
	hsm_pkg::result_t res;
	hsm_pkg::result_t res_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 8'd1;
			phase_q  <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				hsm_pkg::REG_STATUS: status_q <= cfg_data;
				hsm_pkg::REG_PHASE:  phase_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1    <= mode;
			command_s1 <= command;
			data_in_s1 <= data_in;
		end
		if (advance) res_q <= res;
	end

	hsm_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.mode         (mode_s1),
		.command      (command_s1),
		.data_in      (data_in_s1),
		.status_value (status_q),
		.phase_ticks  (phase_q),
		.res          (res)
	);

	assign out_valid = out_valid_q;
	assign sck       = res_q.sck;
	assign data_low  = res_q.data_low;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign raw_value = res_q.raw;
	assign humidity  = res_q.humidity;
	assign ack_error = res_q.ack_error;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int LATENCY = 2;
	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_CAP = 40;

	// clock and pull-down levels over the five steps of a start condition, step 0 in bit 0
	localparam logic [4:0] START_SCK = 5'b11011;
	localparam logic [4:0] START_LOW = 5'b01110;

	localparam logic [7:0] EDGE_BYTES [6] = '{8'd0, 8'd1, 8'd2, 8'd106, 8'd107, 8'd255};

	typedef struct packed {
		hsm_pkg::state_t st;
		logic [7:0] phase_cnt;
		logic [3:0] bit_cnt;
		logic [1:0] byte_cnt;
		logic [7:0] shifter;
		logic [7:0] cmd_byte;
		logic [7:0] raw;
		logic       ack_err;
		logic       init_seq;
	} master_state_t;

	typedef struct packed {
		logic       typed;
		logic [1:0] mode;
		logic [7:0] cmd;
		logic       din;
		hsm_pkg::result_t want;
	} tick_row_t;

	localparam hsm_pkg::result_t IDLE_OUT = '0;

	// result fields: sck, data_low, busy, done, raw, humidity, ack_error
	localparam tick_row_t DIRECTED [26] = '{
		'{1'b1, hsm_pkg::MODE_TICK,    8'h00, 1'b0, IDLE_OUT},
		'{1'b1, MODE_UNUSED,           8'hFF, 1'b1, IDLE_OUT},
		'{1'b1, hsm_pkg::MODE_MEASURE, 8'h05, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b1, hsm_pkg::MODE_INIT,    8'h00, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b1, hsm_pkg::MODE_MEASURE, 8'hAA, 1'b0, '{1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b1, hsm_pkg::MODE_TICK,    8'h3C, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b1, hsm_pkg::MODE_TICK,    8'hC3, 1'b0, '{1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b1, hsm_pkg::MODE_TICK,    8'h00, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b1, hsm_pkg::MODE_TICK,    8'h00, 1'b0, '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h12, 1'b1, '0},
		'{1'b0, MODE_UNUSED,           8'h34, 1'b0, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h56, 1'b1, '0},
		'{1'b0, hsm_pkg::MODE_MEASURE, 8'h78, 1'b0, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h9A, 1'b1, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'hBC, 1'b0, '0},
		'{1'b0, hsm_pkg::MODE_INIT,    8'hDE, 1'b1, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'hF0, 1'b0, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h0F, 1'b1, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h80, 1'b0, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h01, 1'b1, '0},
		'{1'b0, MODE_UNUSED,           8'h7F, 1'b0, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'hFE, 1'b1, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h55, 1'b0, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'hAA, 1'b1, '0},
		'{1'b0, hsm_pkg::MODE_TICK,    8'h00, 1'b0, '0},
		'{1'b1, hsm_pkg::MODE_TICK,    8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b1}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] mode = hsm_pkg::MODE_TICK;
	logic [7:0] command = 8'd0;
	logic       data_in = 1'b1;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       sck;
	logic       data_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] raw_value;
	logic [7:0] humidity;
	logic       ack_error;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = hsm_pkg::REG_STATUS;
	logic [7:0] cfg_data = 8'd0;

	master_state_t    model;
	logic [7:0]       status_cfg = 8'd1;
	logic [7:0]       phase_ticks_cfg = 8'd1;
	logic [7:0]       read_target = 8'd0;
	hsm_pkg::result_t expected [$];
	int               burst_left = 0;
	int               mismatches = 0;
	int               ticks_sent = 0;
	int               measures_done = 0;
	int               inits_done = 0;
	int               nacks_seen = 0;
	int               quiet_cycles = 0;
	logic [9:0]       stall_step = '0;

	humidity_sensor_serial_master u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] half_len();
		return (phase_ticks_cfg == 8'd0) ? 8'd1 : phase_ticks_cfg;
	endfunction

	// advance the sequencer by one tick and return the levels it shows afterwards
	function automatic hsm_pkg::result_t sensor_tick(inout master_state_t s,
			input logic [1:0] m, input logic [7:0] c, input logic d);
		hsm_pkg::result_t r;
		logic    finished;
		int      num;
		r = '0;
		finished = 1'b0;
		if (s.st == hsm_pkg::ST_IDLE) begin
			if (m == hsm_pkg::MODE_MEASURE || m == hsm_pkg::MODE_INIT) begin
				s.ack_err = 1'b0;
				s.phase_cnt = '0;
				s.bit_cnt = '0;
				s.shifter = '0;
				s.init_seq = (m == hsm_pkg::MODE_INIT);
				if (m == hsm_pkg::MODE_MEASURE) begin
					s.cmd_byte = c;
					s.byte_cnt = 2'd0;
					s.st = hsm_pkg::ST_START;
				end else begin
					s.byte_cnt = 2'd3;
					s.st = hsm_pkg::ST_RSTLO;
				end
			end
		end else if (s.st == hsm_pkg::ST_WAIT) begin
			if (!d) begin
				s.st = hsm_pkg::ST_RDLO;
				s.phase_cnt = '0;
				s.bit_cnt = '0;
				s.byte_cnt = '0;
				s.shifter = '0;
			end
		end else if (int'(s.phase_cnt) + 1 < int'(half_len())) begin
			s.phase_cnt = s.phase_cnt + 8'd1;
		end else begin
			s.phase_cnt = '0;
			case (s.st)
				hsm_pkg::ST_RSTLO: s.st = hsm_pkg::ST_RSTHI;
				hsm_pkg::ST_RSTHI: begin
					s.bit_cnt = s.bit_cnt + 4'd1;
					if (s.bit_cnt >= hsm_pkg::RESET_PULSES) begin
						s.bit_cnt = '0;
						s.st = hsm_pkg::ST_START;
					end else begin
						s.st = hsm_pkg::ST_RSTLO;
					end
				end
				hsm_pkg::ST_START: begin
					if (s.bit_cnt < 4'd4) begin
						s.bit_cnt = s.bit_cnt + 4'd1;
					end else begin
						s.bit_cnt = '0;
						// the init flow ends its connection reset with a start, then starts again
						if (s.byte_cnt == 2'd3) begin
							s.byte_cnt = 2'd0;
						end else begin
							s.shifter = s.init_seq ? hsm_pkg::CMD_WRITE_STATUS : s.cmd_byte;
							s.st = hsm_pkg::ST_WRLO;
						end
					end
				end
				hsm_pkg::ST_WRLO: s.st = hsm_pkg::ST_WRHI;
				hsm_pkg::ST_WRHI: begin
					if (s.bit_cnt < 4'd8) begin
						s.shifter = s.shifter << 1;
						s.bit_cnt = s.bit_cnt + 4'd1;
						s.st = hsm_pkg::ST_WRLO;
					end else begin
						if (d) s.ack_err = 1'b1;
						s.bit_cnt = '0;
						if (s.init_seq && s.byte_cnt == 2'd0) begin
							s.shifter = status_cfg;
							s.byte_cnt = 2'd1;
							s.st = hsm_pkg::ST_WRLO;
						end else if (s.init_seq) begin
							finished = 1'b1;
						end else begin
							s.st = hsm_pkg::ST_WAIT;
						end
					end
				end
				hsm_pkg::ST_RDLO: s.st = hsm_pkg::ST_RDHI;
				hsm_pkg::ST_RDHI: begin
					if (s.bit_cnt < 4'd8) begin
						s.shifter = {s.shifter[6:0], d};
						s.bit_cnt = s.bit_cnt + 4'd1;
						s.st = hsm_pkg::ST_RDLO;
					end else begin
						if (s.byte_cnt == 2'd1) s.raw = s.shifter;
						if (s.byte_cnt >= 2'd2) begin
							finished = 1'b1;
						end else begin
							s.byte_cnt = s.byte_cnt + 2'd1;
							s.bit_cnt = '0;
							s.shifter = '0;
							s.st = hsm_pkg::ST_RDLO;
						end
					end
				end
				default: finished = 1'b1;
			endcase
		end
		if (finished) begin
			s.st = hsm_pkg::ST_IDLE;
			s.phase_cnt = '0;
			s.bit_cnt = '0;
			s.byte_cnt = '0;
			r.done = 1'b1;
		end

		case (s.st)
			hsm_pkg::ST_RSTHI: r.sck = 1'b1;
			hsm_pkg::ST_START: begin
				if (s.bit_cnt < 4'd5) begin
					r.sck = START_SCK[s.bit_cnt[2:0]];
					r.data_low = START_LOW[s.bit_cnt[2:0]];
				end
			end
			hsm_pkg::ST_WRLO, hsm_pkg::ST_WRHI: begin
				r.sck = (s.st == hsm_pkg::ST_WRHI);
				r.data_low = (s.bit_cnt < 4'd8) ? ~s.shifter[7] : 1'b0;
			end
			hsm_pkg::ST_RDLO, hsm_pkg::ST_RDHI: begin
				r.sck = (s.st == hsm_pkg::ST_RDHI);
				r.data_low = (s.bit_cnt >= 4'd8 && s.byte_cnt < 2'd2);
			end
			default: ;
		endcase

		num = (s.raw < 8'd107) ? 138 * int'(s.raw) - 230 : 1306 + 122 * int'(s.raw);
		if (num < 0) num = 0;
		r.busy = (s.st != hsm_pkg::ST_IDLE);
		r.raw = s.raw;
		r.humidity = 8'(num / 256);
		r.ack_error = s.ack_err;
		return r;
	endfunction

	// favor bytes at the clamp and at the knee of the humidity curve
	function automatic logic [7:0] pick_target();
		if ($urandom_range(0, 1) == 0) return EDGE_BYTES[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	// choose the next tick like a sensor would answer, with some noise on top
	task automatic next_tick(input bit may_start, output logic [1:0] m, output logic [7:0] c,
			output logic d);
		master_state_t    trial;
		hsm_pkg::result_t peek;
		c = 8'($urandom_range(0, 255));
		d = 1'($urandom_range(0, 1));
		m = hsm_pkg::MODE_TICK;
		if (model.st == hsm_pkg::ST_IDLE) begin
			if (may_start && $urandom_range(0, 3) == 0) begin
				m = ($urandom_range(0, 2) == 0) ? hsm_pkg::MODE_INIT : hsm_pkg::MODE_MEASURE;
				read_target = pick_target();
			end else if ($urandom_range(0, 4) == 0) begin
				m = MODE_UNUSED;
			end
		end else begin
			if (model.st == hsm_pkg::ST_WAIT) begin
				d = ($urandom_range(0, 4) != 0);
			end else if (model.st == hsm_pkg::ST_RDHI && model.byte_cnt == 2'd1
					&& model.bit_cnt < 4'd8
					&& int'(model.phase_cnt) + 1 >= int'(half_len())) begin
				d = read_target[3'd7 - model.bit_cnt[2:0]];
			end
			// aim a request at the finishing tick now and then; it must be dropped
			trial = model;
			peek = sensor_tick(trial, hsm_pkg::MODE_TICK, c, d);
			if (peek.done && may_start && $urandom_range(0, 1) == 0) begin
				m = ($urandom_range(0, 1) == 0) ? hsm_pkg::MODE_INIT : hsm_pkg::MODE_MEASURE;
			end else if ($urandom_range(0, 19) == 0) begin
				m = 2'($urandom_range(0, 3));
			end
		end
	endtask

	task automatic send_tick(input logic [1:0] m, input logic [7:0] c, input logic d);
		hsm_pkg::result_t r;
		int      gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(100, 300);
			else burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		command <= c;
		data_in <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = sensor_tick(model, m, c, d);
		expected.push_back(r);
		ticks_sent++;
		if (r.done) begin
			if (model.init_seq) inits_done++;
			else measures_done++;
			if (r.ack_error) nacks_seen++;
		end
	endtask

	// hold the sender until every result is out and the pipeline has drained
	task automatic settle();
		in_valid <= 1'b0;
		while (expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] status, input logic [7:0] ticks);
		cfg_we <= 1'b1;
		cfg_index <= hsm_pkg::REG_STATUS;
		cfg_data <= status;
		@(posedge clk);
		cfg_index <= hsm_pkg::REG_PHASE;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		status_cfg = status;
		phase_ticks_cfg = ticks;
	endtask

	// random ticks, then ticks that start nothing until the sequencer is back to idle
	task automatic random_ticks(input int n, input bit hold_mid);
		logic [1:0] m;
		logic [7:0] c;
		logic       d;
		int         i;
		for (i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2) settle();
			next_tick(1'b1, m, c, d);
			send_tick(m, c, d);
		end
		while (model.st != hsm_pkg::ST_IDLE) begin
			next_tick(1'b0, m, c, d);
			send_tick(m, c, d);
		end
	endtask

	task automatic run_phase(input logic [7:0] status, input logic [7:0] ticks,
			input logic [1:0] opener, input int n, input bit hold_mid);
		settle();
		load_settings(status, ticks);
		read_target = pick_target();
		send_tick(opener, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		random_ticks(n, hold_mid);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		hsm_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t: result transfer with nothing expected", $time);
			end else begin
				want = expected.pop_front();
				check_field("sck", 8'(want.sck), 8'(sck));
				check_field("data_low", 8'(want.data_low), 8'(data_low));
				check_field("busy_res", 8'(want.busy), 8'(busy_res));
				check_field("done_res", 8'(want.done), 8'(done_res));
				check_field("raw_value", want.raw, raw_value);
				check_field("humidity", want.humidity, humidity);
				check_field("ack_error", 8'(want.ack_error), 8'(ack_error));
			end
		end
	end

	// receiver: ready throughout, then alternating, fixed-pattern and random stall stretches
	always @(posedge clk) begin
		if (arst_n) begin
			stall_step <= stall_step + 10'd1;
			case (stall_step[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= stall_step[0];
				2'd2: out_ready <= (stall_step[2:0] != 3'd0) && (stall_step[2:0] != 3'd3);
				default: out_ready <= ($urandom_range(0, 7) > 2);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		tick_row_t row;
		model = '0;
		model.st = hsm_pkg::ST_IDLE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			send_tick(row.mode, row.cmd, row.din);
			if (row.typed) expected[expected.size() - 1] = row.want;
		end
		random_ticks(100, 1'b0);

		// three-tick half phases with an all-zero status byte
		run_phase(8'h00, 8'd3, hsm_pkg::MODE_INIT, 0, 1'b0);
		run_phase(8'hFF, 8'd0, hsm_pkg::MODE_MEASURE, 100, 1'b1);
		run_phase(8'($urandom_range(0, 255)), 8'd2, hsm_pkg::MODE_TICK, 60, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 4)), hsm_pkg::MODE_INIT,
			60, 1'b0);
		settle();

		$display("%0d ticks: %0d measurements and %0d init sequences completed, %0d with a nack",
			ticks_sent, measures_done, inits_done, nacks_seen);
		$display("half phases of 0, 1, 2, 3 and a short random length; status 0x00, 0x01, 0xFF");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
